// ----- design/ax25fhp_pkg.sv -----
// Shared types, constants and decode helpers for the AX.25 frame header parser.
// No dependencies.
package ax25fhp_pkg;

	localparam int MAX_VIA    = 2;
	localparam int VIA_W      = (MAX_VIA < 2) ? 1 : $clog2(MAX_VIA + 1);
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	localparam logic [2:0] ADDR_LAST_POS = 3'd6;   // seventh byte of an address field
	localparam logic [2:0] LSB_CHECK_END = 3'd5;   // low bit checked on bytes 0..4
	localparam logic [2:0] CALL_MAX      = 3'd6;
	localparam logic [6:0] CHAR_SPACE    = 7'd32;
	localparam logic [7:0] UI_MASK       = 8'hef;
	localparam logic [7:0] UI_CODE       = 8'h03;
	localparam logic [1:0] SLOT_REPEAT   = 2'd2;

	typedef enum logic [1:0] {
		KIND_ADDR = 2'd0,
		KIND_HDR  = 2'd1,
		KIND_DATA = 2'd2,
		KIND_ERR  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ERR_SHORT = 2'd0,
		ERR_LSB   = 2'd1,
		ERR_TRUNC = 2'd2
	} err_t;

	typedef enum logic [1:0] {
		FT_I  = 2'd0,
		FT_S  = 2'd1,
		FT_U  = 2'd2,
		FT_UI = 2'd3
	} ftype_t;

	typedef enum logic [5:0] {
		PH_DEST = 6'b000001,
		PH_SRC  = 6'b000010,
		PH_VIA  = 6'b000100,
		PH_CTRL = 6'b001000,
		PH_PID  = 6'b010000,
		PH_DATA = 6'b100000
	} phase_t;

	// One queued result word. raw holds the seventh address byte or the
	// control/data byte; the back end decodes it by kind.
	typedef struct packed {
		kind_t       kind;
		logic [1:0]  slot;
		logic [47:0] call;
		logic [2:0]  clen;
		logic [7:0]  raw;
		logic [7:0]  pid;
		err_t        err;
		logic        last;
	} rec_t;

	function automatic logic is_ui(input logic [7:0] c);
		return (c & UI_MASK) == UI_CODE;
	endfunction

	function automatic logic needs_pid(input logic [7:0] c);
		return !c[0] || is_ui(c);
	endfunction

	function automatic ftype_t type_of(input logic [7:0] c);
		ftype_t t;
		if (is_ui(c))
			t = FT_UI;
		else if (!c[0])
			t = FT_I;
		else if (c[1])
			t = FT_U;
		else
			t = FT_S;
		return t;
	endfunction

endpackage

// ----- design/ax25_frame_header_parser_top.sv -----
// AX.25 frame header parser, top level: front end, result queue, back end.
// Depends on ax25fhp_pkg, ax25fhp_front, ax25fhp_fifo, ax25fhp_back.

// Takes one frame byte per cycle (push/full) and yields address, control
// header, data or error results through a 4-word result queue (empty/pop).
// A byte is parsed in the cycle it is accepted and its result, if any, can
// be popped the next cycle. full rises only while the queue holds four
// unread results, so with pop kept high the block sustains one byte per
// clock. Headers whose bytes produce no result (address bytes one to six,
// control bytes awaiting a PID) must still be accepted like any other byte.
module ax25_frame_header_parser_top
	import ax25fhp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  in_byte,
	input  logic        frame_end,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  kind,
	output logic [1:0]  addr_slot,
	output logic [47:0] callsign,
	output logic [2:0]  callsign_len,
	output logic [3:0]  ssid,
	output logic        repeated,
	output logic        addr_end,
	output logic [7:0]  value,
	output logic [7:0]  pid,
	output logic [1:0]  ftype,
	output logic [1:0]  error_code,
	output logic        last
);

	logic accept, res_valid;
	rec_t res, head;

	assign accept = push && !full;

	ax25fhp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.in_byte   (in_byte),
		.frame_end (frame_end),
		.res_valid (res_valid),
		.res       (res)
	);

	ax25fhp_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_valid),
		.wr_data (res),
		.rd_en   (pop),
		.rd_data (head),
		.full    (full),
		.empty   (empty)
	);

	ax25fhp_back u_back (
		.rec          (head),
		.kind         (kind),
		.addr_slot    (addr_slot),
		.callsign     (callsign),
		.callsign_len (callsign_len),
		.ssid         (ssid),
		.repeated     (repeated),
		.addr_end     (addr_end),
		.value        (value),
		.pid          (pid),
		.ftype        (ftype),
		.error_code   (error_code),
		.last         (last)
	);

`ifndef NO_ASSERTIONS
	a_no_write_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !res_valid)
		else $error("result produced while queue full");

	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == KIND_ERR) |-> last)
		else $error("error result not marked last");

	a_call_len: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == KIND_ADDR) |-> (callsign_len <= CALL_MAX))
		else $error("callsign length out of range");

	a_no_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |-> !res_valid)
		else $error("result without an accepted byte");
`endif

endmodule

// ----- design/ax25fhp_front.sv -----
// Front end: takes frame bytes, tracks the header position and builds result words.
// Depends on ax25fhp_pkg.
module ax25fhp_front
	import ax25fhp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] in_byte,
	input  logic       frame_end,
	output logic       res_valid,
	output rec_t       res
);

	phase_t            phase_q, phase_n;
	logic [2:0]        pos_q, pos_n;
	logic [VIA_W-1:0]  via_q, via_n, via_inc;
	logic [47:0]       accum_q, accum_n;
	logic [2:0]        len_q, len_n;
	logic              ended_q, ended_n;
	logic              lsb_q, lsb_n;
	logic [7:0]        ctrl_q, ctrl_n;
	logic              disc_q, disc_n;
	logic              frame_rst, call_clr;
	logic [6:0]        ch;
	logic [2:0]        lane;

	assign ch      = in_byte[7:1];
	assign lane    = 3'd5 - len_q;
	assign via_inc = via_q + VIA_W'(1);

	always_comb begin
		phase_n   = phase_q;
		pos_n     = pos_q;
		via_n     = via_q;
		accum_n   = accum_q;
		len_n     = len_q;
		ended_n   = ended_q;
		lsb_n     = lsb_q;
		ctrl_n    = ctrl_q;
		disc_n    = disc_q;
		frame_rst = 1'b0;
		call_clr  = 1'b0;
		res_valid = 1'b0;
		res       = '0;

		if (accept) begin
			if (disc_q) begin
				frame_rst = frame_end;
			end else begin
				case (phase_q)
					PH_DEST, PH_SRC, PH_VIA: begin
						if (pos_q != ADDR_LAST_POS) begin
							if (in_byte[0] && pos_q < LSB_CHECK_END)
								lsb_n = 1'b1;
							if (ch == 7'd0 || ch == CHAR_SPACE || ended_q) begin
								ended_n = 1'b1;
							end else if (len_q < CALL_MAX) begin
								accum_n[{lane, 3'b000} +: 8] = {1'b0, ch};
								len_n = len_q + 3'd1;
							end
							if (frame_end) begin
								res_valid = 1'b1;
								res.kind  = KIND_ERR;
								res.err   = (phase_q == PH_VIA) ? ERR_TRUNC : ERR_SHORT;
								res.last  = 1'b1;
								frame_rst = 1'b1;
							end else begin
								pos_n = pos_q + 3'd1;
							end
						end else if (phase_q == PH_DEST) begin
							if (frame_end) begin
								res_valid = 1'b1;
								res.kind  = KIND_ERR;
								res.err   = ERR_SHORT;
								res.last  = 1'b1;
								frame_rst = 1'b1;
							end else begin
								// a destination low-bit error waits for the source field
								if (!lsb_q) begin
									res_valid = 1'b1;
									res.kind  = KIND_ADDR;
									res.slot  = 2'd0;
									res.call  = accum_q;
									res.clen  = len_q;
									res.raw   = in_byte;
								end
								call_clr = 1'b1;
								phase_n  = PH_SRC;
							end
						end else if (lsb_q || frame_end) begin
							res_valid = 1'b1;
							res.kind  = KIND_ERR;
							res.err   = lsb_q ? ERR_LSB : ERR_TRUNC;
							res.last  = 1'b1;
							frame_rst = frame_end;
							disc_n    = 1'b1;
						end else begin
							res_valid = 1'b1;
							res.kind  = KIND_ADDR;
							res.call  = accum_q;
							res.clen  = len_q;
							res.raw   = in_byte;
							if (phase_q == PH_SRC) begin
								res.slot = 2'd1;
							end else begin
								res.slot = SLOT_REPEAT + 2'(via_q);
								via_n    = via_inc;
							end
							call_clr = 1'b1;
							if (in_byte[0] || via_n >= VIA_W'(MAX_VIA))
								phase_n = PH_CTRL;
							else
								phase_n = PH_VIA;
						end
					end
					PH_CTRL: begin
						ctrl_n = in_byte;
						if (needs_pid(in_byte)) begin
							if (frame_end) begin
								res_valid = 1'b1;
								res.kind  = KIND_ERR;
								res.err   = ERR_TRUNC;
								res.last  = 1'b1;
								frame_rst = 1'b1;
							end else begin
								phase_n = PH_PID;
							end
						end else begin
							res_valid = 1'b1;
							res.kind  = KIND_HDR;
							res.raw   = in_byte;
							res.last  = frame_end;
							frame_rst = frame_end;
							phase_n   = PH_DATA;
						end
					end
					PH_PID: begin
						res_valid = 1'b1;
						res.kind  = KIND_HDR;
						res.raw   = ctrl_q;
						res.pid   = in_byte;
						res.last  = frame_end;
						frame_rst = frame_end;
						phase_n   = PH_DATA;
					end
					default: begin
						res_valid = 1'b1;
						res.kind  = KIND_DATA;
						res.raw   = in_byte;
						res.last  = frame_end;
						frame_rst = frame_end;
					end
				endcase
			end
		end

		if (call_clr || frame_rst) begin
			pos_n   = '0;
			accum_n = '0;
			len_n   = '0;
			ended_n = 1'b0;
		end
		if (frame_rst) begin
			phase_n = PH_DEST;
			via_n   = '0;
			lsb_n   = 1'b0;
			ctrl_n  = '0;
			disc_n  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DEST;
			pos_q   <= '0;
			via_q   <= '0;
			accum_q <= '0;
			len_q   <= '0;
			ended_q <= 1'b0;
			lsb_q   <= 1'b0;
			ctrl_q  <= '0;
			disc_q  <= 1'b0;
		end else begin
			phase_q <= phase_n;
			pos_q   <= pos_n;
			via_q   <= via_n;
			accum_q <= accum_n;
			len_q   <= len_n;
			ended_q <= ended_n;
			lsb_q   <= lsb_n;
			ctrl_q  <= ctrl_n;
			disc_q  <= disc_n;
		end
	end

endmodule

// ----- design/ax25fhp_fifo.sv -----
// Short result queue between the front and back ends, register based.
// Depends on ax25fhp_pkg.
module ax25fhp_fifo
	import ax25fhp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  rec_t wr_data,
	input  logic rd_en,
	output rec_t rd_data,
	output logic full,
	output logic empty
);

	rec_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CW-1:0] cnt_q;
	logic               do_wr, do_rd;

	assign full    = cnt_q == FIFO_CW'(FIFO_DEPTH);
	assign empty   = cnt_q == '0;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + FIFO_AW'(1);
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + FIFO_AW'(1);
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + FIFO_CW'(1);
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - FIFO_CW'(1);
		end
	end

endmodule

// ----- design/ax25fhp_back.sv -----
// Back end: expands the queued result word into the output fields.
// Depends on ax25fhp_pkg.
module ax25fhp_back
	import ax25fhp_pkg::*;
(
	input  rec_t        rec,
	output logic [1:0]  kind,
	output logic [1:0]  addr_slot,
	output logic [47:0] callsign,
	output logic [2:0]  callsign_len,
	output logic [3:0]  ssid,
	output logic        repeated,
	output logic        addr_end,
	output logic [7:0]  value,
	output logic [7:0]  pid,
	output logic [1:0]  ftype,
	output logic [1:0]  error_code,
	output logic        last
);

	logic is_addr, is_hdr;

	assign is_addr = rec.kind == KIND_ADDR;
	assign is_hdr  = rec.kind == KIND_HDR;

	assign kind         = rec.kind;
	assign addr_slot    = rec.slot;
	assign callsign     = rec.call;
	assign callsign_len = rec.clen;
	assign ssid         = is_addr ? rec.raw[4:1] : 4'd0;
	assign repeated     = is_addr && rec.raw[7];
	assign addr_end     = is_addr && rec.raw[0];
	assign value        = (is_hdr || rec.kind == KIND_DATA) ? rec.raw : 8'd0;
	assign pid          = rec.pid;
	assign ftype        = is_hdr ? type_of(rec.raw) : FT_I;
	assign error_code   = rec.err;
	assign last         = rec.last;

endmodule

// ----- tb/ax25fhp_result_checker.sv -----
// Result checker for the AX.25 frame header parser: predicts result words from
// accepted frame bytes and compares every popped word against the prediction.
// Depends on ax25fhp_pkg.
module ax25fhp_result_checker
	import ax25fhp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [7:0]  in_byte,
	input  logic        frame_end,
	input  logic        empty,
	input  logic        pop,
	input  logic [1:0]  kind,
	input  logic [1:0]  addr_slot,
	input  logic [47:0] callsign,
	input  logic [2:0]  callsign_len,
	input  logic [3:0]  ssid,
	input  logic        repeated,
	input  logic        addr_end,
	input  logic [7:0]  value,
	input  logic [7:0]  pid,
	input  logic [1:0]  ftype,
	input  logic [1:0]  error_code,
	input  logic        last,
	output int          waiting,
	output int          fail_count
);

	typedef struct {
		kind_t       kind;
		logic [1:0]  slot;
		logic [47:0] call;
		logic [2:0]  clen;
		logic [3:0]  ssid;
		logic        rep;
		logic        endm;
		logic [7:0]  val;
		logic [7:0]  pid;
		ftype_t      ftype;
		err_t        err;
		logic        last;
	} parse_word_t;

	parse_word_t due_words[$];
	int fails = 0;

	// predicted parser state
	logic [2:0]  fld_pos;
	phase_t      stage;
	int          via_seen;
	logic [47:0] call_bits;
	logic [2:0]  call_cnt;
	logic        call_stop;
	logic        addr_bit_err;
	logic [7:0]  ctrl_held;
	logic        skipping;

	assign fail_count = fails;

	function automatic parse_word_t blank_word();
		parse_word_t w;
		w.kind  = KIND_ADDR;
		w.slot  = '0;
		w.call  = '0;
		w.clen  = '0;
		w.ssid  = '0;
		w.rep   = 1'b0;
		w.endm  = 1'b0;
		w.val   = '0;
		w.pid   = '0;
		w.ftype = FT_I;
		w.err   = ERR_SHORT;
		w.last  = 1'b0;
		return w;
	endfunction

	task automatic new_field();
		fld_pos   = '0;
		call_bits = '0;
		call_cnt  = '0;
		call_stop = 1'b0;
	endtask

	task automatic restart();
		new_field();
		stage        = PH_DEST;
		via_seen     = 0;
		addr_bit_err = 1'b0;
		ctrl_held    = '0;
		skipping     = 1'b0;
	endtask

	task automatic raise_error(input err_t code, input logic fe);
		parse_word_t w;
		w = blank_word();
		w.kind = KIND_ERR;
		w.err  = code;
		w.last = 1'b1;
		due_words.insert(due_words.size(), w);
		if (fe)
			restart();
		else
			skipping = 1'b1;
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic fe);
		parse_word_t w;
		logic [6:0] ch;
		w  = blank_word();
		ch = b[7:1];
		if (skipping) begin
			if (fe)
				restart();
			return;
		end
		case (stage)
		PH_DEST, PH_SRC, PH_VIA: begin
			if (fld_pos < ADDR_LAST_POS) begin
				if (b[0] && fld_pos < LSB_CHECK_END)
					addr_bit_err = 1'b1;
				// callsign stops at the first zero or space
				if (ch == 7'd0 || ch == CHAR_SPACE || call_stop) begin
					call_stop = 1'b1;
				end else if (call_cnt < CALL_MAX) begin
					call_bits[47 - 8 * int'(call_cnt) -: 8] = {1'b0, ch};
					call_cnt = call_cnt + 3'd1;
				end
				if (fe)
					raise_error(stage == PH_VIA ? ERR_TRUNC : ERR_SHORT, 1'b1);
				else
					fld_pos = fld_pos + 3'd1;
				return;
			end
			w.call = call_bits;
			w.clen = call_cnt;
			w.ssid = b[4:1];
			w.rep  = b[7];
			w.endm = b[0];
			if (stage == PH_DEST) begin
				if (fe) begin
					raise_error(ERR_SHORT, 1'b1);
					return;
				end
				// a bad destination is reported once the source is complete
				if (!addr_bit_err)
					due_words.insert(due_words.size(), w);
				new_field();
				stage = PH_SRC;
			end else if (addr_bit_err) begin
				raise_error(ERR_LSB, fe);
			end else if (fe) begin
				raise_error(ERR_TRUNC, 1'b1);
			end else begin
				if (stage == PH_SRC) begin
					w.slot = 2'd1;
				end else begin
					w.slot = SLOT_REPEAT + 2'(via_seen);
					via_seen++;
				end
				due_words.insert(due_words.size(), w);
				new_field();
				stage = (b[0] || via_seen >= MAX_VIA) ? PH_CTRL : PH_VIA;
			end
		end
		PH_CTRL: begin
			ctrl_held = b;
			if (!b[0] || (b & UI_MASK) == UI_CODE) begin
				if (fe)
					raise_error(ERR_TRUNC, 1'b1);
				else
					stage = PH_PID;
			end else begin
				w.kind  = KIND_HDR;
				w.val   = b;
				w.ftype = b[1] ? FT_U : FT_S;
				w.last  = fe;
				due_words.insert(due_words.size(), w);
				if (fe)
					restart();
				else
					stage = PH_DATA;
			end
		end
		PH_PID: begin
			w.kind  = KIND_HDR;
			w.val   = ctrl_held;
			w.pid   = b;
			w.ftype = ((ctrl_held & UI_MASK) == UI_CODE) ? FT_UI : FT_I;
			w.last  = fe;
			due_words.insert(due_words.size(), w);
			if (fe)
				restart();
			else
				stage = PH_DATA;
		end
		default: begin
			w.kind = KIND_DATA;
			w.val  = b;
			w.last = fe;
			due_words.insert(due_words.size(), w);
			if (fe)
				restart();
		end
		endcase
	endtask

	task automatic check_field(input string name, input logic [47:0] want,
			input logic [47:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fails++;
		end
	endtask

	task automatic compare_word();
		parse_word_t w;
		if (due_words.size() == 0) begin
			$error("result word with nothing expected: kind %0d", kind);
			fails++;
			return;
		end
		w = due_words.pop_front();
		check_field("kind", 48'(w.kind), 48'(kind));
		check_field("addr_slot", 48'(w.slot), 48'(addr_slot));
		check_field("callsign", w.call, callsign);
		check_field("callsign_len", 48'(w.clen), 48'(callsign_len));
		check_field("ssid", 48'(w.ssid), 48'(ssid));
		check_field("repeated", 48'(w.rep), 48'(repeated));
		check_field("addr_end", 48'(w.endm), 48'(addr_end));
		check_field("value", 48'(w.val), 48'(value));
		check_field("pid", 48'(w.pid), 48'(pid));
		check_field("ftype", 48'(w.ftype), 48'(ftype));
		check_field("error_code", 48'(w.err), 48'(error_code));
		check_field("last", 48'(w.last), 48'(last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			due_words.delete();
			restart();
			waiting <= 0;
		end else begin
			if (pop && !empty)
				compare_word();
			if (push && !full)
				parse_byte(in_byte, frame_end);
			waiting <= due_words.size();
		end
	end

endmodule

// ----- tb/ax25_frame_header_parser_top_tb.sv -----
// Testbench top for the AX.25 frame header parser: clock, reset, frame stimulus
// with random pacing of the byte input and the result queue, and the final verdict.
// Depends on ax25fhp_pkg, ax25_frame_header_parser_top, ax25fhp_result_checker.
module ax25_frame_header_parser_top_tb;
	import ax25fhp_pkg::*;

	localparam int          ITEM_TARGET  = 500;
	localparam int          LIMIT_CYCLES = 300000;
	localparam logic [7:0]  PID_NONE     = 8'hf0;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic [7:0]  in_byte = 8'h00;
	logic        frame_end = 1'b0;
	logic        pop = 1'b0;
	logic        full, empty;
	logic [1:0]  kind, addr_slot, ftype, error_code;
	logic [47:0] callsign;
	logic [2:0]  callsign_len;
	logic [3:0]  ssid;
	logic        repeated, addr_end, last;
	logic [7:0]  value, pid;
	int          waiting, fail_count;

	logic [7:0] frame_q[$];
	int items_sent = 0;
	int frame_no = 0;
	int idle_pct = 0;
	int stall_pct = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	ax25_frame_header_parser_top dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .in_byte(in_byte), .frame_end(frame_end),
		.empty(empty), .pop(pop),
		.kind(kind), .addr_slot(addr_slot), .callsign(callsign),
		.callsign_len(callsign_len), .ssid(ssid), .repeated(repeated),
		.addr_end(addr_end), .value(value), .pid(pid), .ftype(ftype),
		.error_code(error_code), .last(last)
	);

	ax25fhp_result_checker chk (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .in_byte(in_byte), .frame_end(frame_end),
		.empty(empty), .pop(pop),
		.kind(kind), .addr_slot(addr_slot), .callsign(callsign),
		.callsign_len(callsign_len), .ssid(ssid), .repeated(repeated),
		.addr_end(addr_end), .value(value), .pid(pid), .ftype(ftype),
		.error_code(error_code), .last(last),
		.waiting(waiting), .fail_count(fail_count)
	);

	always @(posedge clk)
		pop <= ($urandom_range(0, 99) >= stall_pct);

	task automatic put_byte(input logic [7:0] b, input logic fe);
		while ($urandom_range(0, 99) < idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push      <= 1'b1;
		in_byte   <= b;
		frame_end <= fe;
		do begin
			@(posedge clk);
		end while (full);
		items_sent++;
	endtask

	task automatic send_frame();
		foreach (frame_q[i])
			put_byte(frame_q[i], i == frame_q.size() - 1);
	endtask

	// hold the sender off until every predicted word has been popped
	task automatic drain();
		push <= 1'b0;
		do begin
			@(posedge clk);
		end while (waiting != 0);
	endtask

	task automatic add_address(input logic end_bit, input logic bad_low);
		int n, k;
		logic [6:0] c;
		logic [7:0] b;
		n = $urandom_range(0, 6);
		for (int i = 0; i < 6; i++) begin
			if (i < n) begin
				case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: c = 7'h41 + 7'($urandom_range(0, 25));
				6, 7:             c = 7'h30 + 7'($urandom_range(0, 9));
				default:          c = 7'($urandom);
				endcase
			end else begin
				c = ($urandom_range(0, 7) == 0) ? 7'd0 : CHAR_SPACE;
			end
			b = {c, 1'b0};
			if (i == 5)
				b[0] = 1'($urandom_range(0, 1));   // low bit of the sixth word is exempt
			frame_q.insert(frame_q.size(), b);
		end
		if (bad_low) begin
			k = frame_q.size() - 6 + $urandom_range(0, 4);
			frame_q[k] = frame_q[k] | 8'h01;
		end
		b    = 8'($urandom);
		b[0] = end_bit;
		frame_q.insert(frame_q.size(), b);
	endtask

	task automatic add_control();
		ftype_t t;
		logic [7:0] c;
		t = ftype_t'($urandom_range(0, 3));
		c = 8'($urandom);
		case (t)
		FT_I:    c[0] = 1'b0;
		FT_S:    c[1:0] = 2'b01;
		FT_U:    c[1:0] = 2'b11;
		default: c = UI_CODE | ($urandom_range(0, 1) ? 8'h10 : 8'h00);
		endcase
		frame_q.insert(frame_q.size(), c);
		if (!c[0] || (c & UI_MASK) == UI_CODE)
			frame_q.insert(frame_q.size(), $urandom_range(0, 1) ? PID_NONE : 8'($urandom));
		repeat ($urandom_range(0, 3))
			frame_q.insert(frame_q.size(), 8'($urandom));
	endtask

	task automatic build_frame();
		int pick, nvia, bad, keep;
		pick = $urandom_range(0, 99);
		frame_q.delete();
		if (pick >= 88) begin
			repeat ($urandom_range(1, 24))
				frame_q.insert(frame_q.size(), 8'($urandom));
			return;
		end
		nvia = $urandom_range(0, MAX_VIA);
		bad  = (pick >= 55 && pick < 70) ? $urandom_range(0, nvia + 1) : -1;
		add_address($urandom_range(0, 3) == 0, bad == 0);
		add_address(nvia == 0, bad == 1);
		// at the repeater limit the end mark may stay clear
		for (int v = 0; v < nvia; v++)
			add_address(v == nvia - 1 && !(nvia == MAX_VIA && $urandom_range(0, 1)),
				bad == v + 2);
		add_control();
		if (pick >= 70) begin
			// cut short, mostly around address field boundaries
			if ($urandom_range(0, 1))
				keep = 7 * $urandom_range(1, 3) + $urandom_range(0, 1) - 1;
			else
				keep = $urandom_range(1, frame_q.size() - 1);
			if (keep > frame_q.size() - 1)
				keep = frame_q.size() - 1;
			while (frame_q.size() > keep)
				void'(frame_q.pop_back());
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		frame_q = '{8'hff};
		send_frame();
		// UI frame through one repeater; space padding, exempt low bit on the
		// sixth word, zero terminator inside the source callsign
		frame_q = '{8'h86, 8'ha2, 8'h40, 8'h40, 8'h40, 8'h41, 8'he0,
			8'h9c, 8'h60, 8'h00, 8'h82, 8'h84, 8'h86, 8'h7e,
			8'ha4, 8'h8a, 8'h98, 8'h82, 8'hb2, 8'h62, 8'he3,
			8'h13, PID_NONE, 8'h00};
		send_frame();

		while (items_sent < ITEM_TARGET) begin
			if (frame_no % 4 == 0) begin
				drain();
				case ((frame_no / 4) % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 62; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 62; end
				default: begin idle_pct = 7; stall_pct = 7; end
				endcase
			end
			build_frame();
			send_frame();
			frame_no++;
		end

		idle_pct  = 0;
		stall_pct = 0;
		drain();
		repeat (16) @(posedge clk);
		if (fail_count == 0)
			$display("ax25_frame_header_parser_top_tb: done, clean");
		else
			$display("ax25_frame_header_parser_top_tb: done, errors");
		$finish;
	end

	initial begin
		#(12 * LIMIT_CYCLES);
		$display("ax25_frame_header_parser_top_tb: done, errors");
		$finish;
	end

endmodule
